// ===== design/mer_pkg.sv =====
package mer_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_INIT,
    ST_SW_A,
    ST_SW_B,
    ST_SW_C,
    ST_SW_D,
    ST_SW_E,
    ST_PLOT
  } state_e;

endpackage

// ===== design/midpoint_ellipse_rasterizer.sv =====
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+-------------------------------------------------
// input    | in_valid_i  | in_ready_o  | operation_i center_x_i center_y_i radius_x_i radius_y_i
// output   | out_valid_o | out_ready_i | right_x_o left_x_o lower_y_o upper_y_o last_o
//
// a step: accept, then one add-only update into the output register
// a step that crosses into region 2 makes five passes through the shared multiplier first
// a start makes three passes through the shared multiplier and gives no result
// rst_ni clears the sequencer, the output valid and the walk flags; no memory to clear
// a stalled output holds the update cycle until the waiting transaction is taken
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic [RADIUS_BITS-1:0]        radius_x_i,
  input  logic [RADIUS_BITS-1:0]        radius_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS:0]    right_x_o,
  output logic signed [COORD_BITS:0]    left_x_o,
  output logic signed [COORD_BITS:0]    lower_y_o,
  output logic signed [COORD_BITS:0]    upper_y_o,
  output logic                          last_o
);

  localparam int R     = RADIUS_BITS;
  localparam int C     = COORD_BITS;
  localparam int OUT_W = C + 1;
  localparam int XW    = R + 1;
  localparam int YW    = R + 2;
  localparam int SQ_W  = 2 * R;
  localparam int SL_W  = 3 * R + 4;
  localparam int MUL_W = 2 * R + 4;
  localparam int DEC_W = 2 * MUL_W;
  localparam int SUM_W = (OUT_W > YW) ? OUT_W : YW;

  mer_pkg::state_e state_q, state_d;

  logic [C-1:0]     cx_q, cy_q;
  logic [R-1:0]     rad_x_q, rad_y_q;
  logic [SQ_W-1:0]  rx2_q, ry2_q;
  logic [XW-1:0]    x_q, x_d;
  logic [YW-1:0]    y_q, y_d;
  logic [SL_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [DEC_W-1:0] dec_q, dec_d, acc_q;
  logic [MUL_W-1:0] tmp_q;
  logic             region_q, active_q;

  logic             out_valid_q;
  logic [OUT_W-1:0] right_x_q, left_x_q, lower_y_q, upper_y_q;
  logic             last_q;

  logic             in_fire, plot_go, need_switch;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [DEC_W-1:0] prod;

  assign in_fire     = in_valid_i && in_ready_o;
  assign need_switch = !region_q && ($signed(sx_q) > $signed(sy_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (operation_i == mer_pkg::OP_START) begin
            state_d = mer_pkg::ST_SQ_RX;
          end else if (active_q) begin
            state_d = need_switch ? mer_pkg::ST_SW_A : mer_pkg::ST_PLOT;
          end
        end
      end
      mer_pkg::ST_SQ_RX: state_d = mer_pkg::ST_SQ_RY;
      mer_pkg::ST_SQ_RY: state_d = mer_pkg::ST_INIT;
      mer_pkg::ST_INIT:  state_d = mer_pkg::ST_IDLE;
      mer_pkg::ST_SW_A:  state_d = mer_pkg::ST_SW_B;
      mer_pkg::ST_SW_B:  state_d = mer_pkg::ST_SW_C;
      mer_pkg::ST_SW_C:  state_d = mer_pkg::ST_SW_D;
      mer_pkg::ST_SW_D:  state_d = mer_pkg::ST_SW_E;
      mer_pkg::ST_SW_E:  state_d = mer_pkg::ST_PLOT;
      mer_pkg::ST_PLOT: begin
        if (plot_go) begin
          state_d = mer_pkg::ST_IDLE;
        end
      end
      default: state_d = mer_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  logic [YW-1:0]    ym1, ym1_abs;
  logic [R+1:0]     two_x1;
  assign ym1     = y_q - YW'(1);
  assign ym1_abs = ym1[YW-1] ? (YW'(0) - ym1) : ym1;
  assign two_x1  = {x_q, 1'b1};

  always_comb begin
    in_ready_o = 1'b0;
    plot_go    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      mer_pkg::ST_IDLE: in_ready_o = 1'b1;
      mer_pkg::ST_SQ_RX: begin
        mul_a = MUL_W'(rad_x_q);
        mul_b = MUL_W'(rad_x_q);
      end
      mer_pkg::ST_SQ_RY: begin
        mul_a = MUL_W'(rad_y_q);
        mul_b = MUL_W'(rad_y_q);
      end
      mer_pkg::ST_INIT: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = MUL_W'(rad_y_q);
      end
      mer_pkg::ST_SW_A: begin
        mul_a = MUL_W'(two_x1);
        mul_b = MUL_W'(two_x1);
      end
      mer_pkg::ST_SW_B: begin
        mul_a = MUL_W'(ry2_q);
        mul_b = tmp_q;
      end
      mer_pkg::ST_SW_C: begin
        mul_a = MUL_W'(ym1_abs);
        mul_b = MUL_W'(ym1_abs);
      end
      mer_pkg::ST_SW_D: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = tmp_q;
      end
      mer_pkg::ST_SW_E: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = MUL_W'(ry2_q);
      end
      mer_pkg::ST_PLOT: plot_go = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // the one shared multiplier, its product lands in a register every time
  assign prod = mul_a * mul_b;

  // one walk iteration
  logic [SL_W-1:0]  two_ry2, two_rx2, sx_inc, sy_dec;
  logic [DEC_W-1:0] ry2_w, rx2_w, sxn_w, syn_w;
  logic             dec_neg, dec_pos;

  assign two_ry2 = {{(SL_W-SQ_W-1){1'b0}}, ry2_q, 1'b0};
  assign two_rx2 = {{(SL_W-SQ_W-1){1'b0}}, rx2_q, 1'b0};
  assign sx_inc  = sx_q + two_ry2;
  assign sy_dec  = sy_q - two_rx2;
  assign ry2_w   = DEC_W'(ry2_q);
  assign rx2_w   = DEC_W'(rx2_q);
  assign dec_neg = dec_q[DEC_W-1];
  assign dec_pos = !dec_q[DEC_W-1] && (dec_q != '0);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxn_w = '0;
    syn_w = '0;
    dec_d = dec_q;
    if (!region_q) begin
      x_d   = x_q + XW'(1);
      sx_d  = sx_inc;
      sxn_w = {{(DEC_W-SL_W){sx_inc[SL_W-1]}}, sx_inc};
      if (dec_neg) begin
        dec_d = dec_q + ((sxn_w + ry2_w) << 2);
      end else begin
        y_d   = y_q - YW'(1);
        sy_d  = sy_dec;
        syn_w = {{(DEC_W-SL_W){sy_dec[SL_W-1]}}, sy_dec};
        dec_d = dec_q + ((sxn_w - syn_w + ry2_w) << 2);
      end
    end else begin
      y_d   = y_q - YW'(1);
      sy_d  = sy_dec;
      syn_w = {{(DEC_W-SL_W){sy_dec[SL_W-1]}}, sy_dec};
      if (dec_pos) begin
        dec_d = dec_q + ((rx2_w - syn_w) << 2);
      end else begin
        x_d   = x_q + XW'(1);
        sx_d  = sx_inc;
        sxn_w = {{(DEC_W-SL_W){sx_inc[SL_W-1]}}, sx_inc};
        dec_d = dec_q + ((sxn_w - syn_w + rx2_w) << 2);
      end
    end
  end

  // four symmetric points
  logic [SUM_W-1:0] cx_w, cy_w, x_w, y_w, sum_rx, sum_lx, sum_ly, sum_uy;
  assign cx_w   = {{(SUM_W-C){cx_q[C-1]}}, cx_q};
  assign cy_w   = {{(SUM_W-C){cy_q[C-1]}}, cy_q};
  assign x_w    = {{(SUM_W-XW){1'b0}}, x_q};
  assign y_w    = {{(SUM_W-YW){y_q[YW-1]}}, y_q};
  assign sum_rx = cx_w + x_w;
  assign sum_lx = cx_w - x_w;
  assign sum_ly = cy_w + y_w;
  assign sum_uy = cy_w - y_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mer_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      region_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mer_pkg::ST_PLOT && plot_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        mer_pkg::ST_INIT: begin
          active_q <= 1'b1;
          region_q <= 1'b0;
        end
        mer_pkg::ST_SW_E: region_q <= 1'b1;
        mer_pkg::ST_PLOT: begin
          if (plot_go && y_d[YW-1]) begin
            active_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_fire && operation_i == mer_pkg::OP_START) begin
          cx_q    <= center_x_i;
          cy_q    <= center_y_i;
          rad_x_q <= radius_x_i;
          rad_y_q <= radius_y_i;
        end
      end
      mer_pkg::ST_SQ_RX: rx2_q <= prod[SQ_W-1:0];
      mer_pkg::ST_SQ_RY: ry2_q <= prod[SQ_W-1:0];
      mer_pkg::ST_INIT: begin
        x_q   <= '0;
        y_q   <= YW'(rad_y_q);
        sx_q  <= '0;
        sy_q  <= {prod[SL_W-2:0], 1'b0};
        dec_q <= (ry2_w << 2) - (prod << 2) + rx2_w;
      end
      mer_pkg::ST_SW_A: tmp_q <= prod[MUL_W-1:0];
      mer_pkg::ST_SW_B: acc_q <= prod;
      mer_pkg::ST_SW_C: tmp_q <= prod[MUL_W-1:0];
      mer_pkg::ST_SW_D: acc_q <= acc_q + (prod << 2);
      mer_pkg::ST_SW_E: dec_q <= acc_q - (prod << 2);
      mer_pkg::ST_PLOT: begin
        if (plot_go) begin
          right_x_q <= sum_rx[OUT_W-1:0];
          left_x_q  <= sum_lx[OUT_W-1:0];
          lower_y_q <= sum_ly[OUT_W-1:0];
          upper_y_q <= sum_uy[OUT_W-1:0];
          last_q    <= y_d[YW-1];
          x_q       <= x_d;
          y_q       <= y_d;
          sx_q      <= sx_d;
          sy_q      <= sy_d;
          dec_q     <= dec_d;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign right_x_o   = right_x_q;
  assign left_x_o    = left_x_q;
  assign lower_y_o   = lower_y_q;
  assign upper_y_o   = upper_y_q;
  assign last_o      = last_q;

  a_plot_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mer_pkg::ST_PLOT |-> active_q)
    else $error("plot without an active walk");

  a_region_one_slope : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mer_pkg::ST_PLOT && !region_q) |-> ($signed(sx_q) <= $signed(sy_q)))
    else $error("region 1 iteration past the slope crossover");

  a_switch_sets_region : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mer_pkg::ST_SW_E |=> (region_q && state_q == mer_pkg::ST_PLOT))
    else $error("region switch did not enter region 2");

  a_last_ends_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mer_pkg::ST_PLOT && plot_go && y_d[YW-1]) |=> (!active_q && last_o))
    else $error("final point set did not end the walk");

endmodule
